// ===== rtl/core/float32_divide_truncating_defines.svh =====
// Assertion macros for the float32 truncating divider checker.
// No dependencies.
`ifndef FLOAT32_DIVIDE_TRUNCATING_DEFINES_SVH
`define FLOAT32_DIVIDE_TRUNCATING_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FDT_ASSERT_IMPL(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FDT_ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

// ===== rtl/core/fdt_pkg.sv =====
// Shared types and constants for the float32 truncating divider.
// No dependencies.
package fdt_pkg;
    localparam int unsigned SigW    = 24;
    localparam int unsigned Stages  = 24;  // one cell per quotient bit
    localparam int unsigned FracW   = 23;
    localparam int unsigned ExpW    = 8;
    localparam logic [9:0]  ExpBias = 10'd127;

    // Data handed from one divider cell to the next
    typedef struct packed {
        logic             valid;
        logic [SigW:0]    rem;     // partial remainder, below 2*divisor
        logic [SigW-1:0]  den;     // divisor significand
        logic [SigW-1:0]  quo;     // quotient bits developed so far
        logic             adjust;  // dividend significand below divisor
        logic [9:0]       exp;     // signed biased exponent
        logic             sign;
    } fdt_cell_t;
endpackage

// ===== rtl/core/fdt_cell.sv =====
// One restoring-division cell: one quotient bit per cycle while advance is high, registered.
// Depends on fdt_pkg.
module fdt_cell import fdt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  fdt_cell_t cell_in,
    output fdt_cell_t cell_out
);
    fdt_cell_t   cell_reg, cell_next;
    logic [SigW+1:0] diff;

    // compare-subtract, then double the remainder for the next bit
    always_comb begin
        cell_next = cell_in;
        diff      = {1'b0, cell_in.rem} - {2'b00, cell_in.den};
        if (!diff[SigW+1]) begin
            cell_next.rem = {diff[SigW-1:0], 1'b0};
            cell_next.quo = {cell_in.quo[SigW-2:0], 1'b1};
        end else begin
            cell_next.rem = {cell_in.rem[SigW-1:0], 1'b0};
            cell_next.quo = {cell_in.quo[SigW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (advance) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;
endmodule

// ===== rtl/core/float32_divide_truncating.sv =====
// Channel   | Direction | Payload
// s_        | in        | s_dividend_bits, s_divisor_bits
// m_        | out       | m_quotient_bits
// One accepted transaction per cycle while the chain is not stalled.
// Each result passes through the 24-cell restoring divider chain and then the output register.
// The whole chain stalls while m_valid is high and m_ready low.
// Synchronous active-low reset clears all valid bits.
// Top level of the float32 truncating divider. Depends on fdt_pkg, fdt_cell.
module float32_divide_truncating import fdt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_dividend_bits,
    input  logic [31:0] s_divisor_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_quotient_bits
);
    fdt_cell_t chain [Stages+1];
    logic advance;
    logic [SigW-1:0] sn, sd;
    logic            out_valid_reg;
    logic [31:0]     out_bits_reg, out_bits_next;
    fdt_cell_t       last;
    logic [FracW-1:0] frac;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;

    // unpack operands into the head of the chain
    always_comb begin
        sn = {1'b1, s_dividend_bits[FracW-1:0]};
        sd = {1'b1, s_divisor_bits[FracW-1:0]};
        chain[0].valid  = s_valid;
        chain[0].rem    = {1'b0, sn};
        chain[0].den    = sd;
        chain[0].quo    = '0;
        chain[0].adjust = sn < sd;
        chain[0].exp    = {2'b00, s_dividend_bits[30:23]} - {2'b00, s_divisor_bits[30:23]}
                          + ExpBias - {9'd0, sn < sd};
        chain[0].sign   = s_dividend_bits[31] ^ s_divisor_bits[31];
    end

    for (genvar i = 0; i < Stages; i++) begin : g_cell
        fdt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .cell_in (chain[i]),
            .cell_out(chain[i+1])
        );
    end

    // pack result; exponent range check on signed 10-bit value
    always_comb begin
        last = chain[Stages];
        frac = last.adjust ? {last.quo[FracW-2:0], 1'b0} : last.quo[FracW-1:0];
        if (last.exp[9] || last.exp == 10'd0 || last.exp[8]) begin
            out_bits_next = '0;
        end else begin
            out_bits_next = {last.sign, last.exp[ExpW-1:0], frac};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_bits_reg <= out_bits_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_quotient_bits = out_bits_reg;
endmodule

// ===== rtl/core/fdt_checker.sv =====
// Port-level checker for the float32 truncating divider, with its bind.
// Depends on float32_divide_truncating_defines.svh.
`include "float32_divide_truncating_defines.svh"
module fdt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_quotient_bits
);
    `FDT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_quotient_bits), "result dropped while stalled")
    `FDT_ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_valid, s_ready, "input blocked with empty output")
    `FDT_ASSERT_IMPL(a_ready_stall, aclk, aresetn, m_valid && !m_ready, !s_ready, "input taken during stall")
endmodule

bind float32_divide_truncating fdt_checker u_fdt_checker (.*);
